// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define SFS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFS_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hdl/sfs_pkg.sv -----
// ----------------------------------------------------------------------------
// sfs_pkg
// Types, codes and helper functions of the stiff string step core.
// ----------------------------------------------------------------------------
package sfs_pkg;

  localparam int MAX_POINTS_DEF = 256;

  localparam logic [1:0] CMD_STEP = 2'd0;
  localparam logic [1:0] CMD_ADD  = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [3:0] REG_B0   = 4'd0;
  localparam logic [3:0] REG_BSS  = 4'd1;
  localparam logic [3:0] REG_B1   = 4'd2;
  localparam logic [3:0] REG_B2   = 4'd3;
  localparam logic [3:0] REG_C0   = 4'd4;
  localparam logic [3:0] REG_C1   = 4'd5;
  localparam logic [3:0] REG_GRID = 4'd6;
  localparam logic [3:0] REG_PICK = 4'd7;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [7:0]         point_index;
    logic signed [31:0] add_value;
  } sfs_in_t;

  typedef struct packed {
    logic signed [31:0] displacement;
    logic               saturated;
  } sfs_out_t;

  typedef struct packed {
    logic [3:0]  index;
    logic [31:0] data;
  } sfs_cfg_t;

  typedef struct packed {
    logic valid;
    logic clear;
  } sfs_mac_ctl_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_STEP, S_PICK, S_PICKW,
    S_ADD0, S_ADD1, S_ADD2, S_RD, S_RDW, S_EMIT
  } sfs_state_t;

  // Bank holding level (rotation + offset) mod 3.
  function automatic logic [1:0] bank_of(input logic [1:0] rot, input logic [1:0] off);
    logic [2:0] s;
    s = {1'b0, rot} + {1'b0, off};
    return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
  endfunction

  // Grid offset of term k, biased by two.
  function automatic logic [2:0] term_pos(input logic [2:0] k);
    logic [2:0] p;
    case (k)
      3'd0: p = 3'd2;
      3'd1: p = 3'd1;
      3'd2: p = 3'd3;
      3'd3: p = 3'd0;
      3'd4: p = 3'd4;
      3'd5: p = 3'd2;
      3'd6: p = 3'd1;
      default: p = 3'd3;
    endcase
    return p;
  endfunction

  // Saturates to 32 bits; bit 32 of the result is the saturation flag.
  function automatic logic [32:0] sat32(input logic signed [40:0] x);
    logic [32:0] r;
    if (x > 41'sh0_7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
    else if (x < -41'sh0_8000_0000) r = {1'b1, 32'h8000_0000};
    else r = {1'b0, x[31:0]};
    return r;
  endfunction

endpackage

// ----- hdl/sfs_chan_if.sv -----
// ----------------------------------------------------------------------------
// sfs_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface sfs_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- hdl/sfs_store.sv -----
// ----------------------------------------------------------------------------
// sfs_store
// Three banks of displacement memory, one per time level, registered read.
// ----------------------------------------------------------------------------
module sfs_store
  import sfs_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF,
  localparam int AW = $clog2(MAX_POINTS)
) (
  input  logic          clk,
  input  logic [1:0]    rd_bank,
  input  logic [AW-1:0] rd_addr,
  output logic [31:0]   rd_data,
  input  logic          wr_en,
  input  logic          wr_all,
  input  logic [1:0]    wr_bank,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data
);

  logic [31:0] q_r [3];
  logic [1:0]  sel_r;

  for (genvar b = 0; b < 3; b++) begin : g_bank
    logic [31:0] mem [MAX_POINTS];
    always_ff @(posedge clk) begin
      if (wr_en && (wr_all || (wr_bank == 2'(b)))) begin
        mem[wr_addr] <= wr_data;
      end
      q_r[b] <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    sel_r <= rd_bank;
  end

  always_comb begin
    case (sel_r)
      2'd0:    rd_data = q_r[0];
      2'd1:    rd_data = q_r[1];
      default: rd_data = q_r[2];
    endcase
  end

endmodule

// ----- hdl/sfs_mac.sv -----
// ----------------------------------------------------------------------------
// sfs_mac
// Shared multiply-accumulate unit with rounding and saturation to Q8.24.
// ----------------------------------------------------------------------------
module sfs_mac
  import sfs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  sfs_mac_ctl_t       ctl,
  input  logic signed [31:0] coef,
  input  logic signed [31:0] sample,
  output logic [31:0]        result,
  output logic               sat
);

  logic signed [63:0] prod_r;
  logic               pv_r;
  logic signed [63:0] acc_r;
  logic signed [63:0] rnd;
  logic [32:0]        s;

  always_ff @(posedge clk) begin
    prod_r <= coef * sample;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r  <= 1'b0;
      acc_r <= '0;
    end else begin
      pv_r <= ctl.valid;
      if (ctl.clear) begin
        acc_r <= '0;
      end else if (pv_r) begin
        acc_r <= acc_r + (prod_r >>> 4);
      end
    end
  end

  assign rnd    = acc_r + 64'sh80_0000;
  assign s      = sat32({rnd[63], rnd[63:24]});
  assign result = s[31:0];
  assign sat    = s[32];

endmodule

// ----- hdl/stiff_string_fdtd_step_core.sv -----
// ----------------------------------------------------------------------------
// stiff_string_fdtd_step_core
// Step: each interior point takes eight products through the one shared
// multiplier, then rounding; every other point is written as zero.
// Add writes nothing when the index lies outside the interior.
// After reset a clearing pass over all MAX_POINTS addresses zeroes the store.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stiff_string_fdtd_step_core
  import sfs_pkg::*;
#(
  parameter int MAX_POINTS = MAX_POINTS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  sfs_chan_if.sink   in_ch,
  sfs_chan_if.source out_ch,
  sfs_chan_if.sink   cfg_ch
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = ((AW > 8) ? AW : 8) + 2;
  localparam logic [CW-1:0] NMAX = CW'(MAX_POINTS - 1);

  sfs_state_t state_r, state_nxt;
  logic [AW-1:0] l_r, l_nxt, clr_r, clr_nxt;
  logic [3:0] tcnt_r, tcnt_nxt;
  logic [1:0] rot_r, rot_nxt;
  logic sat_r, sat_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic signed [31:0] addv_r, addv_nxt;
  logic tv_r, tv_nxt, mask_r, mask_nxt;
  logic signed [31:0] coef_r, coef_nxt;
  logic [31:0] res_r, res_nxt;
  logic res_sat_r, res_sat_nxt;
  logic out_valid_r, out_load;
  sfs_out_t out_r;

  logic signed [31:0] b0_r, bss_r, b1_r, b2_r, c0_r, c1_r;
  logic [7:0] grid_r, pick_r;

  logic [1:0] rd_bank, wr_bank;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0] rd_data, wr_data;
  logic wr_en, wr_all;
  sfs_mac_ctl_t mac_ctl;
  logic [31:0] mac_res;
  logic mac_sat;

  logic [CW-1:0] n_eff, l_w, pos, idx_w, pick_w;
  logic interior, edge_pt, pos_ok, idx_ok, pick_ok;
  logic [2:0] k;
  logic [32:0] add_s;

  sfs_store #(.MAX_POINTS(MAX_POINTS)) u_store (
    .clk(clk), .rd_bank(rd_bank), .rd_addr(rd_addr), .rd_data(rd_data),
    .wr_en(wr_en), .wr_all(wr_all), .wr_bank(wr_bank), .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  sfs_mac u_mac (
    .clk(clk), .rst_n(rst_n), .ctl(mac_ctl), .coef(coef_r),
    .sample(mask_r ? $signed(rd_data) : 32'sd0), .result(mac_res), .sat(mac_sat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b0_r   <= '0;
      bss_r  <= '0;
      b1_r   <= '0;
      b2_r   <= '0;
      c0_r   <= '0;
      c1_r   <= '0;
      grid_r <= 8'd4;
      pick_r <= 8'd1;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.payload.index)
        REG_B0:   b0_r   <= cfg_ch.payload.data;
        REG_BSS:  bss_r  <= cfg_ch.payload.data;
        REG_B1:   b1_r   <= cfg_ch.payload.data;
        REG_B2:   b2_r   <= cfg_ch.payload.data;
        REG_C0:   c0_r   <= cfg_ch.payload.data;
        REG_C1:   c1_r   <= cfg_ch.payload.data;
        REG_GRID: grid_r <= cfg_ch.payload.data[7:0];
        REG_PICK: pick_r <= cfg_ch.payload.data[7:0];
        default: ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);

  always_comb begin
    if (CW'(grid_r) < CW'(4)) n_eff = CW'(4);
    else if (CW'(grid_r) > NMAX) n_eff = NMAX;
    else n_eff = CW'(grid_r);
  end

  assign l_w      = CW'(l_r);
  assign interior = (l_w >= CW'(1)) && (l_w < n_eff);
  assign edge_pt  = (l_w == CW'(1)) || (l_w == n_eff - CW'(1));
  assign k        = tcnt_r[2:0];
  assign pos      = l_w + CW'(term_pos(k));
  assign pos_ok   = (pos >= CW'(3)) && (pos < n_eff + CW'(2));
  assign idx_w    = CW'(idx_r);
  assign idx_ok   = (idx_w >= CW'(1)) && (idx_w < n_eff);
  assign pick_w   = CW'(pick_r);
  assign pick_ok  = (pick_w >= CW'(1)) && (pick_w < n_eff);
  assign add_s    = sat32(41'($signed({rd_data[31], rd_data}) + 33'(addv_r)));

  always_comb begin
    state_nxt   = state_r;
    l_nxt       = l_r;
    clr_nxt     = clr_r;
    tcnt_nxt    = tcnt_r;
    rot_nxt     = rot_r;
    sat_nxt     = sat_r;
    idx_nxt     = idx_r;
    addv_nxt    = addv_r;
    tv_nxt      = 1'b0;
    mask_nxt    = mask_r;
    coef_nxt    = coef_r;
    res_nxt     = res_r;
    res_sat_nxt = res_sat_r;
    out_load    = 1'b0;
    rd_bank     = bank_of(rot_r, 2'd0);
    rd_addr     = AW'(idx_r);
    wr_en       = 1'b0;
    wr_all      = 1'b0;
    wr_bank     = bank_of(rot_r, 2'd2);
    wr_addr     = l_r;
    wr_data     = '0;
    mac_ctl     = '{valid: tv_r, clear: 1'b0};
    unique case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_all  = 1'b1;
        wr_addr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(MAX_POINTS - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          idx_nxt  = in_ch.payload.point_index;
          addv_nxt = in_ch.payload.add_value;
          l_nxt    = '0;
          tcnt_nxt = '0;
          sat_nxt  = 1'b0;
          unique case (in_ch.payload.cmd)
            CMD_STEP: state_nxt = S_STEP;
            CMD_ADD:  state_nxt = S_ADD0;
            CMD_READ: state_nxt = S_RD;
            default: ;
          endcase
        end
      end
      S_STEP: begin
        if (!interior || (tcnt_r == 4'd10)) begin
          wr_en    = 1'b1;
          wr_data  = interior ? mac_res : 32'd0;
          sat_nxt  = sat_r | (interior & mac_sat);
          mac_ctl.clear = 1'b1;
          tcnt_nxt = '0;
          if (l_r == AW'(MAX_POINTS - 1)) begin
            rot_nxt   = bank_of(rot_r, 2'd2);
            state_nxt = S_PICK;
          end else begin
            l_nxt = l_r + AW'(1);
          end
        end else begin
          tcnt_nxt = tcnt_r + 4'd1;
          if (tcnt_r < 4'd8) begin
            rd_bank  = bank_of(rot_r, (k >= 3'd5) ? 2'd1 : 2'd0);
            rd_addr  = AW'(pos - CW'(2));
            tv_nxt   = 1'b1;
            mask_nxt = pos_ok;
            case (k)
              3'd0:         coef_nxt = edge_pt ? bss_r : b0_r;
              3'd1, 3'd2:   coef_nxt = b1_r;
              3'd3, 3'd4:   coef_nxt = b2_r;
              3'd5:         coef_nxt = c0_r;
              default:      coef_nxt = c1_r;
            endcase
          end
        end
      end
      S_PICK: begin
        rd_addr   = AW'(pick_r);
        mask_nxt  = pick_ok;
        state_nxt = S_PICKW;
      end
      S_PICKW: begin
        res_nxt     = mask_r ? rd_data : 32'd0;
        res_sat_nxt = sat_r;
        state_nxt   = S_EMIT;
      end
      S_ADD0: begin
        state_nxt = idx_ok ? S_ADD1 : S_IDLE;
      end
      S_ADD1: begin
        wr_en     = 1'b1;
        wr_bank   = bank_of(rot_r, 2'd0);
        wr_addr   = AW'(idx_r);
        wr_data   = add_s[31:0];
        rd_bank   = bank_of(rot_r, 2'd1);
        state_nxt = S_ADD2;
      end
      S_ADD2: begin
        wr_en     = 1'b1;
        wr_bank   = bank_of(rot_r, 2'd1);
        wr_addr   = AW'(idx_r);
        wr_data   = add_s[31:0];
        state_nxt = S_IDLE;
      end
      S_RD: begin
        mask_nxt  = idx_ok;
        state_nxt = S_RDW;
      end
      S_RDW: begin
        res_nxt     = mask_r ? rd_data : 32'd0;
        res_sat_nxt = 1'b0;
        state_nxt   = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      rot_r       <= '0;
      tv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      l_r         <= '0;
      tcnt_r      <= '0;
      sat_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      rot_r   <= rot_nxt;
      tv_r    <= tv_nxt;
      l_r     <= l_nxt;
      tcnt_r  <= tcnt_nxt;
      sat_r   <= sat_nxt;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    addv_r    <= addv_nxt;
    mask_r    <= mask_nxt;
    coef_r    <= coef_nxt;
    res_r     <= res_nxt;
    res_sat_r <= res_sat_nxt;
    if (out_load) begin
      out_r.displacement <= res_r;
      out_r.saturated    <= res_sat_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;

  `SFS_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (state_r == S_CLR), "reset did not start clearing")
  `SFS_ASSERT(a_rot_range, clk, rst_n, rot_r != 2'd3, "level rotation out of range")
  `SFS_ASSERT(a_bank_split, clk, rst_n, ((state_r == S_STEP) && wr_en) |-> (wr_bank != rd_bank), "step writes the bank it reads")
  `SFS_ASSERT(a_emit_src, clk, rst_n, $rose(out_valid_r) |-> ($past(state_r) == S_EMIT), "result without emit state")

endmodule
